FILE: rtl/core/sample_packetizer_ring_core_macros.svh
// Assertion macros used by the packetizer checker.
`ifndef SAMPLE_PACKETIZER_RING_CORE_MACROS_SVH
`define SAMPLE_PACKETIZER_RING_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spr check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spr check failed");

`endif

FILE: rtl/core/spr_pkg.sv
// Types and constants of the sample packetizer ring.
package spr_pkg;

    localparam int MAX_PACKET = 512;
    localparam int SLOTS      = 16;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int OFF_W      = $clog2(MAX_PACKET);
    localparam int ADDR_W     = SLOT_W + OFF_W;
    localparam int LEN_W      = 10;
    localparam int CNT_W      = 32;
    localparam int MODE_W     = 3;
    localparam int PCNT_W     = 16;
    localparam int DATA_W     = 32;

    localparam logic [LEN_W-1:0] SIZE_RESET = LEN_W'(256);
    localparam logic [LEN_W-1:0] SIZE_MAX   = LEN_W'(MAX_PACKET);

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE   = 3'd0,
        MODE_FINISH  = 3'd1,
        MODE_READ    = 3'd2,
        MODE_ADVANCE = 3'd3,
        MODE_REWIND  = 3'd4,
        MODE_CLEAR   = 3'd5
    } t_mode;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] sample;
        logic [OFF_W-1:0]  word_offset;
        logic [PCNT_W-1:0] packet_count;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              available;
        logic              finished;
        logic [OFF_W-1:0]  partial_fill;
    } t_out_item;

    typedef struct packed {
        logic              available;
        logic              finished;
        logic [OFF_W-1:0]  partial_fill;
    } t_status;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              len_wr_en;
        logic [SLOT_W-1:0] len_wr_slot;
        logic [LEN_W-1:0]  len_wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic [SLOT_W-1:0] rd_slot;
    } t_mem_req;

endpackage

FILE: rtl/core/spr_store.sv
// Packet word memory and per-slot length memory, both with registered reads.
module spr_store (
    input  logic                         i_clk,
    input  spr_pkg::t_mem_req            i_req,
    output logic [spr_pkg::DATA_W-1:0]   o_rd_data,
    output logic [spr_pkg::LEN_W-1:0]    o_rd_len
);

    logic [spr_pkg::DATA_W-1:0] r_words [spr_pkg::SLOTS*spr_pkg::MAX_PACKET];
    logic [spr_pkg::LEN_W-1:0]  r_lens  [spr_pkg::SLOTS];
    logic [spr_pkg::DATA_W-1:0] r_rd_data;
    logic [spr_pkg::LEN_W-1:0]  r_rd_len;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_words[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_words[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.len_wr_en) begin
            r_lens[i_req.len_wr_slot] <= i_req.len_wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_len <= r_lens[i_req.rd_slot];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_len  = r_rd_len;

endmodule

FILE: rtl/core/spr_ctrl.sv
// Write/read counters, fill count and finish flag; issues the memory accesses.
module spr_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  spr_pkg::t_in_item           i_item,
    input  logic                        i_cfg_write,
    input  logic [spr_pkg::LEN_W-1:0]   i_cfg_data,
    output spr_pkg::t_mem_req           o_req,
    output spr_pkg::t_status            o_status
);

    logic [spr_pkg::LEN_W-1:0] r_size, n_size;
    logic [spr_pkg::CNT_W-1:0] r_wc, n_wc;
    logic [spr_pkg::CNT_W-1:0] r_rc, n_rc;
    logic [spr_pkg::OFF_W-1:0] r_fill, n_fill;
    logic                      r_done, n_done;
    logic [spr_pkg::LEN_W-1:0] fill_inc;
    logic [spr_pkg::CNT_W-1:0] pcount;

    always_comb begin
        n_size   = r_size;
        n_wc     = r_wc;
        n_rc     = r_rc;
        n_fill   = r_fill;
        n_done   = r_done;
        fill_inc = {1'b0, r_fill} + spr_pkg::LEN_W'(1);
        pcount   = {{(spr_pkg::CNT_W-spr_pkg::PCNT_W){1'b0}}, i_item.packet_count};

        o_req.wr_en       = 1'b0;
        o_req.wr_addr     = {r_wc[spr_pkg::SLOT_W-1:0], r_fill};
        o_req.wr_data     = i_item.sample;
        o_req.len_wr_en   = 1'b0;
        o_req.len_wr_slot = r_wc[spr_pkg::SLOT_W-1:0];
        o_req.len_wr_data = r_size;
        o_req.rd_en       = 1'b0;
        o_req.rd_addr     = {r_rc[spr_pkg::SLOT_W-1:0], i_item.word_offset};
        o_req.rd_slot     = r_rc[spr_pkg::SLOT_W-1:0];

        if (i_cfg_write) begin
            // zero acts as one, anything past the slot size is capped
            if (i_cfg_data == '0) begin
                n_size = spr_pkg::LEN_W'(1);
            end else if (i_cfg_data > spr_pkg::SIZE_MAX) begin
                n_size = spr_pkg::SIZE_MAX;
            end else begin
                n_size = i_cfg_data;
            end
            n_wc   = '0;
            n_rc   = '0;
            n_fill = '0;
            n_done = 1'b0;
        end else if (i_accept) begin
            unique case (i_item.mode)
                spr_pkg::MODE_WRITE: begin
                    o_req.wr_en = 1'b1;
                    if (fill_inc >= r_size) begin
                        o_req.len_wr_en = 1'b1;
                        n_wc   = r_wc + spr_pkg::CNT_W'(1);
                        n_fill = '0;
                    end else begin
                        n_fill = fill_inc[spr_pkg::OFF_W-1:0];
                    end
                end
                spr_pkg::MODE_FINISH: begin
                    o_req.len_wr_en   = 1'b1;
                    o_req.len_wr_data = {1'b0, r_fill};
                    n_wc   = r_wc + spr_pkg::CNT_W'(1);
                    n_fill = '0;
                    n_done = 1'b1;
                end
                spr_pkg::MODE_READ: begin
                    o_req.rd_en = 1'b1;
                end
                spr_pkg::MODE_ADVANCE: begin
                    n_rc = r_rc + pcount;
                end
                spr_pkg::MODE_REWIND: begin
                    n_rc = (pcount >= r_rc) ? '0 : r_rc - pcount;
                end
                spr_pkg::MODE_CLEAR: begin
                    n_wc   = '0;
                    n_rc   = '0;
                    n_fill = '0;
                end
                default: begin
                end
            endcase
        end

        o_status.available    = (n_rc < n_wc);
        o_status.finished     = n_done;
        o_status.partial_fill = n_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= spr_pkg::SIZE_RESET;
            r_wc   <= '0;
            r_rc   <= '0;
            r_fill <= '0;
            r_done <= 1'b0;
        end else begin
            r_size <= n_size;
            r_wc   <= n_wc;
            r_rc   <= n_rc;
            r_fill <= n_fill;
            r_done <= n_done;
        end
    end

endmodule

FILE: rtl/core/sample_packetizer_ring_core.sv
// Sample packetizer ring: groups 32-bit audio words into packets in a 16-slot ring.
//
// Input channel (i_in_valid / i_in_item / o_in_stall): one item per accepted
// edge; the mode field picks write, finish, read word, advance, rewind or clear.
// Output channel (o_out_valid / o_out_item / i_out_stall): exactly one result
// item per input item, in order, carrying the read word and the ring status.
// Configuration channel (i_cfg_valid / i_cfg_data / o_cfg_ready): writes the
// packet size and clears counts, fill and finished flag; ready is low while an
// item sits in the read stage or an input item is offered.
// An accepted item passes through the memory-read stage, which holds the
// registered read of the packet and length memories, into the output register.
// Throughput: one item per clock while the receiver keeps up.
// When the receiver stalls, the output register holds its item, one more item
// can be taken into the memory-read stage, and then o_in_stall rises.
// Reset (synchronous, active low) clears the counters, the finished flag and
// the pipeline; packet size returns to 256. Packet memories are not cleared.
module sample_packetizer_ring_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  spr_pkg::t_in_item          i_in_item,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output spr_pkg::t_out_item         o_out_item,
    input  logic                       i_out_stall,
    input  logic                       i_cfg_valid,
    input  logic [spr_pkg::LEN_W-1:0]  i_cfg_data,
    output logic                       o_cfg_ready
);

    spr_pkg::t_mem_req          mem_req;
    spr_pkg::t_status           status;
    logic [spr_pkg::DATA_W-1:0] rd_data;
    logic [spr_pkg::LEN_W-1:0]  rd_len;
    logic                       accept;
    logic                       cfg_write;
    logic                       s1_move;

    logic                       r_s1_valid;
    logic                       r_s1_read;
    logic [spr_pkg::OFF_W-1:0]  r_s1_offset;
    spr_pkg::t_status           r_s1_status;
    logic                       r_out_valid;
    spr_pkg::t_out_item         r_out_item;
    spr_pkg::t_out_item         n_out_item;

    assign s1_move     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !s1_move;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = !r_s1_valid && !i_in_valid;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    spr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .i_cfg_write (cfg_write),
        .i_cfg_data  (i_cfg_data),
        .o_req       (mem_req),
        .o_status    (status)
    );

    spr_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data),
        .o_rd_len  (rd_len)
    );

    // memory read data stays put while the item waits, since nothing is accepted then
    always_comb begin
        n_out_item.read_data    = (r_s1_read && ({1'b0, r_s1_offset} < rd_len))
                                  ? rd_data : '0;
        n_out_item.available    = r_s1_status.available;
        n_out_item.finished     = r_s1_status.finished;
        n_out_item.partial_fill = r_s1_status.partial_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_read   <= (i_in_item.mode == spr_pkg::MODE_READ);
            r_s1_offset <= i_in_item.word_offset;
            r_s1_status <= status;
        end
        if (s1_move && r_s1_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/core/spr_checker.sv
// Port-level checks of the packetizer core, bound into every core instance.
`include "sample_packetizer_ring_core_macros.svh"

module spr_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       o_in_stall,
    input  logic                       o_out_valid,
    input  spr_pkg::t_out_item         o_out_item,
    input  logic                       i_out_stall
);

    // input side only backs up behind a stalled result
    `SPR_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // no result straight out of reset
    `SPR_ASSERT_NOW(a_reset_empty, $past(!i_rst_n), !o_out_valid)

    // a held result keeps its payload
    `SPR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
                     o_out_valid && $stable(o_out_item))

endmodule

bind sample_packetizer_ring_core spr_checker u_spr_checker (.*);

FILE: tb/sv/tb_sample_packetizer_ring_core.sv
// Self-checking testbench for the sample packetizer ring core.
module tb_sample_packetizer_ring_core;
    import spr_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;
    localparam int STREAM_PHASES = 7;
    localparam int PHASE_ITEMS   = 157;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    t_in_item            in_item = '0;
    logic                in_stall;
    logic                out_valid;
    t_out_item           out_item;
    logic                out_stall = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [LEN_W-1:0]    cfg_data = '0;
    logic                cfg_ready;

    int                  in_gap_max = 0;
    int                  out_gap_max = 0;
    int                  err_count = 0;
    int                  cycle_cnt = 0;

    // Mirror of the ring state
    logic [DATA_W-1:0]   ring_words [SLOTS][MAX_PACKET];
    logic [LEN_W-1:0]    slot_len [SLOTS];
    bit                  slot_len_set [SLOTS];
    logic [CNT_W-1:0]    wr_pkts = '0;
    logic [CNT_W-1:0]    rd_pkts = '0;
    int                  fill_words = 0;
    logic                done_seen = 1'b0;
    logic [LEN_W-1:0]    pkt_size = SIZE_RESET;

    t_out_item           pending_results [$];

    sample_packetizer_ring_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_out_item predict_ring_op(t_in_item it);
        t_out_item         res;
        int                size;
        logic [SLOT_W-1:0] ws;
        logic [SLOT_W-1:0] rs;
        size = (pkt_size == '0) ? 1 : (pkt_size > SIZE_MAX) ? MAX_PACKET : int'(pkt_size);
        ws = wr_pkts[SLOT_W-1:0];
        rs = rd_pkts[SLOT_W-1:0];
        res = '0;
        case (it.mode)
            MODE_WRITE: begin
                if (fill_words < MAX_PACKET)
                    ring_words[ws][fill_words] = it.sample;
                fill_words++;
                if (fill_words >= size) begin
                    slot_len[ws] = LEN_W'(size);
                    slot_len_set[ws] = 1'b1;
                    wr_pkts++;
                    fill_words = 0;
                end
            end
            MODE_FINISH: begin
                slot_len[ws] = LEN_W'(fill_words);
                slot_len_set[ws] = 1'b1;
                wr_pkts++;
                fill_words = 0;
                done_seen = 1'b1;
            end
            MODE_READ: begin
                if (LEN_W'(it.word_offset) < slot_len[rs])
                    res.read_data = ring_words[rs][it.word_offset];
            end
            MODE_ADVANCE: rd_pkts = rd_pkts + CNT_W'(it.packet_count);
            MODE_REWIND: begin
                if (CNT_W'(it.packet_count) >= rd_pkts)
                    rd_pkts = '0;
                else
                    rd_pkts = rd_pkts - CNT_W'(it.packet_count);
            end
            MODE_CLEAR: begin
                wr_pkts = '0;
                rd_pkts = '0;
                fill_words = 0;
            end
            default: ;
        endcase
        res.available = (rd_pkts < wr_pkts);
        res.finished = done_seen;
        res.partial_fill = fill_words[OFF_W-1:0];
        return res;
    endfunction

    function automatic t_in_item make_item(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] sample,
                                           int offset, int count);
        t_in_item it;
        it.mode = mode;
        it.sample = sample;
        it.word_offset = OFF_W'(offset);
        it.packet_count = PCNT_W'(count);
        return it;
    endfunction

    // Mostly well-formed stream traffic, biased toward completed packets and valid reads
    function automatic t_in_item pick_stream_op();
        t_in_item it;
        int       r;
        int       len;
        logic [SLOT_W-1:0] rs;
        rs = rd_pkts[SLOT_W-1:0];
        len = slot_len_set[rs] ? int'(slot_len[rs]) : 0;
        it.sample = $urandom;
        it.word_offset = OFF_W'($urandom_range(0, MAX_PACKET - 1));
        it.packet_count = PCNT_W'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 55) begin
            it.mode = MODE_WRITE;
        end else if (r < 60) begin
            it.mode = MODE_FINISH;
        end else if (r < 80) begin
            it.mode = MODE_READ;
            if (len > 0 && r < 77)
                it.word_offset = OFF_W'($urandom_range(0, len - 1));
        end else if (r < 88) begin
            it.mode = MODE_ADVANCE;
            if (r == 87)
                it.packet_count = PCNT_W'($urandom_range(0, 65535));
            else if (rd_pkts < wr_pkts)
                it.packet_count = PCNT_W'(1);
        end else if (r < 93) begin
            it.mode = MODE_REWIND;
            if (r == 92)
                it.packet_count = PCNT_W'($urandom_range(0, 65535));
        end else if (r < 95) begin
            it.mode = MODE_CLEAR;
        end else if (r < 97) begin
            it.mode = r[0] ? MODE_SPARE_A : MODE_SPARE_B;
        end else begin
            it.mode = MODE_W'($urandom_range(0, 7));
            it.packet_count = PCNT_W'($urandom_range(0, 65535));
        end
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        gap = (in_gap_max > 0) ? $urandom_range(0, in_gap_max) : 0;
        // a slot length is undefined until written: never read such a slot
        if (it.mode == MODE_READ && !slot_len_set[rd_pkts[SLOT_W-1:0]])
            it.mode = MODE_SPARE_A;
        if (gap > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (in_stall);
        pending_results.push_back(predict_ring_op(it));
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_packet_size(logic [LEN_W-1:0] value);
        wait_results_drained();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        pkt_size = value;
        wr_pkts = '0;
        rd_pkts = '0;
        fill_words = 0;
        done_seen = 1'b0;
    endtask

    // Receiver: random stall before each result
    initial begin
        int n;
        forever begin
            n = (out_gap_max > 0) ? $urandom_range(0, out_gap_max) : 0;
            if (n > 0) begin
                @(negedge i_clk);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
                @(negedge i_clk);
                out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: %p", out_item);
                err_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (out_item.read_data !== exp_res.read_data) begin
                    $error("read_data expected %h actual %h", exp_res.read_data, out_item.read_data);
                    err_count++;
                end
                if (out_item.available !== exp_res.available) begin
                    $error("available expected %b actual %b", exp_res.available, out_item.available);
                    err_count++;
                end
                if (out_item.finished !== exp_res.finished) begin
                    $error("finished expected %b actual %b", exp_res.finished, out_item.finished);
                    err_count++;
                end
                if (out_item.partial_fill !== exp_res.partial_fill) begin
                    $error("partial_fill expected %0d actual %0d",
                           exp_res.partial_fill, out_item.partial_fill);
                    err_count++;
                end
            end
        end
    end

    // Two-word packets: reads in and past a packet, finish with and without fill,
    // rewind clamping, far advance, clear keeping the finished flag, spare modes
    task automatic test_basic_ops();
        in_gap_max = 4;
        out_gap_max = 4;
        write_packet_size(LEN_W'(2));
        send_item(make_item(MODE_WRITE, 32'hFFFF_FFFF, 0, 0));
        send_item(make_item(MODE_WRITE, 32'h0000_0000, 0, 0));
        send_item(make_item(MODE_READ, '0, 0, 0));
        send_item(make_item(MODE_READ, '0, 1, 0));
        send_item(make_item(MODE_READ, '0, MAX_PACKET - 1, 0));
        send_item(make_item(MODE_WRITE, 32'hA5A5_5A5A, 0, 0));
        send_item(make_item(MODE_FINISH, '0, 0, 0));
        send_item(make_item(MODE_FINISH, '0, 0, 0));
        send_item(make_item(MODE_ADVANCE, '0, 0, 1));
        send_item(make_item(MODE_READ, '0, 0, 0));
        send_item(make_item(MODE_READ, '0, 1, 0));
        send_item(make_item(MODE_ADVANCE, '0, 0, 1));
        send_item(make_item(MODE_READ, '0, 0, 0));
        send_item(make_item(MODE_REWIND, '0, 0, 65535));
        send_item(make_item(MODE_READ, '0, 0, 0));
        send_item(make_item(MODE_ADVANCE, '0, 0, 65535));
        send_item(make_item(MODE_REWIND, '0, 0, 65533));
        send_item(make_item(MODE_CLEAR, '0, 0, 0));
        send_item(make_item(MODE_SPARE_A, 32'h1234_5678, 511, 65535));
        send_item(make_item(MODE_SPARE_B, '0, 0, 0));
        send_item(make_item(MODE_WRITE, 32'h0F0F_F0F0, 0, 0));
        send_item(make_item(MODE_READ, '0, 1, 0));
    endtask

    // Size zero acts as one word per packet
    task automatic test_zero_size();
        write_packet_size('0);
        send_item(make_item(MODE_WRITE, 32'hDEAD_BEEF, 0, 0));
        send_item(make_item(MODE_READ, '0, 0, 0));
        send_item(make_item(MODE_READ, '0, 1, 0));
        write_packet_size(LEN_W'(1));
        send_item(make_item(MODE_WRITE, 32'h8000_0001, 0, 0));
        send_item(make_item(MODE_READ, '0, 0, 0));
    endtask

    // Full 512-word packet, then an oversized setting that saturates
    task automatic test_full_packet();
        in_gap_max = 2;
        out_gap_max = 2;
        write_packet_size(SIZE_MAX);
        repeat (MAX_PACKET) send_item(make_item(MODE_WRITE, $urandom, 0, 0));
        send_item(make_item(MODE_READ, '0, 0, 0));
        send_item(make_item(MODE_READ, '0, MAX_PACKET - 1, 0));
        send_item(make_item(MODE_READ, '0, $urandom_range(1, MAX_PACKET - 2), 0));
        write_packet_size('1);
        repeat (3) send_item(make_item(MODE_WRITE, $urandom, 0, 0));
        send_item(make_item(MODE_FINISH, '0, 0, 0));
        send_item(make_item(MODE_READ, '0, 2, 0));
        send_item(make_item(MODE_READ, '0, 3, 0));
    endtask

    task automatic test_random_stream();
        int sz;
        for (int p = 0; p < STREAM_PHASES; p++) begin
            case (p % 4)
                0: begin in_gap_max = 0;  out_gap_max = 0;  end
                1: begin in_gap_max = 18; out_gap_max = 18; end
                2: begin in_gap_max = 0;  out_gap_max = 18; end
                default: begin in_gap_max = 18; out_gap_max = 0; end
            endcase
            if (p == 2)
                sz = 0;
            else if (p == 5)
                sz = $urandom_range(20, 40);
            else
                sz = $urandom_range(1, 8);
            write_packet_size(LEN_W'(sz));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // sender holds off until the ring has answered everything
                if (i == PHASE_ITEMS / 2 && p == 1)
                    wait_results_drained();
                send_item(pick_stream_op());
            end
        end
    endtask

    initial begin
        foreach (slot_len_set[s]) slot_len_set[s] = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_zero_size();
        test_full_packet();
        test_random_stream();
        wait_results_drained();
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
